// ===== hdl/mspid_pkg.sv =====
// Package for the motor speed PID core: widths, fixed-point constants,
// register indexes and the control struct of the shared multiply-accumulate unit.
// No dependencies.
package mspid_pkg;

  localparam int CountW = 16;
  localparam int ErrW   = 17;
  localparam int DiffW  = 18;
  localparam int SumW   = 32;
  localparam int GainW  = 16;
  localparam int PowerW = 10;
  localparam int YW     = 27;
  localparam int OpaW   = 33;
  localparam int OpbW   = 20;
  localparam int AccW   = 54;
  localparam int FracW  = 12;
  localparam int RecipShift = 36;
  localparam int CfgIdxW = 3;

  localparam logic signed [CountW-1:0] RunawayLimit = 16'sd5500;
  localparam logic [PowerW-1:0] RunawayPower = 10'd80;
  localparam logic [PowerW-1:0] PowerSat = 10'd1023;
  localparam logic signed [AccW-1:0] OffsetQ12 = 54'sd1415184;
  localparam logic [OpbW-1:0] RecipQ24 = 20'd969333;

  localparam logic [GainW-1:0] GainPReset = 16'd1843;
  localparam logic [GainW-1:0] GainIReset = 16'd205;
  localparam logic [GainW-1:0] GainDReset = 16'd0;
  localparam logic [PowerW-1:0] PowerMaxReset = 10'd350;
  localparam logic [PowerW-1:0] PowerMinReset = 10'd80;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_POWER_MAX = 3'd3,
    REG_POWER_MIN = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_SET,
    MAC_MUL,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t                  op;
    logic signed [OpaW-1:0]   opa;
    logic        [OpbW-1:0]   opb;
    logic signed [AccW-1:0]   init;
  } mac_ctl_t;

endpackage

// ===== hdl/mspid_mac.sv =====
// Shared multiply-accumulate unit: signed operand times unsigned coefficient,
// loaded, stored or added into one wide accumulator. Depends on mspid_pkg.
module mspid_mac (
  input  logic                             clk,
  input  mspid_pkg::mac_ctl_t              ctl,
  output logic signed [mspid_pkg::AccW-1:0] acc
);
  import mspid_pkg::*;

  logic signed [AccW-1:0] prod;

  assign prod = ctl.opa * $signed({1'b0, ctl.opb});

  always_ff @(posedge clk) begin
    case (ctl.op)
      MAC_SET: acc <= ctl.init;
      MAC_MUL: acc <= prod;
      MAC_ADD: acc <= acc + prod;
      default: acc <= acc;
    endcase
  end

endmodule

// ===== hdl/motor_speed_pid_core.sv =====
// Top level of the motor speed PID core: sequencer, state, config registers
// and output register. Depends on mspid_pkg and mspid_mac.

// One sample item in, one result item out. A sample whose measured count has
// magnitude above 5500 returns power 80 with runaway set and leaves the loop
// state alone. Otherwise the core forms error = target - measured, adds it to
// a saturating 32-bit integral, builds the corrected target in Q12 as
// target + kp*err + ki*sum + kd*(err - previous error) with Q4.12 gains, maps
// it to power through (x + 345.504) * (1/17.308), truncates, takes negative
// power as 0, saturates at 1023 and clamps to power_max, then power_min.
// A normal item steps through ERR, MP, MI, MD, OFS, MR and DONE before
// the core is ready for the next one (a runaway item skips to DONE), as the
// single shared multiplier forms the three gain products and the reciprocal.
// Sample_ready is high only while the sequencer idles; the result register
// holds a finished item until it is taken, and the core stalls in its last
// step if an earlier result is still waiting. Config writes (cfg_ready is
// always high) take effect at once and belong to idle periods, which the
// core does not enforce; indexes past the register list are dropped.
module motor_speed_pid_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_ready,
  input  logic signed [mspid_pkg::CountW-1:0] target_count,
  input  logic signed [mspid_pkg::CountW-1:0] measured_count,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic        [mspid_pkg::PowerW-1:0] motor_power,
  output logic                                runaway,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic       [mspid_pkg::CfgIdxW-1:0] cfg_index,
  input  logic         [mspid_pkg::GainW-1:0] cfg_data
);
  import mspid_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MP,
    ST_MI,
    ST_MD,
    ST_OFS,
    ST_MR,
    ST_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [GainW-1:0]  gain_p;
  logic [GainW-1:0]  gain_i;
  logic [GainW-1:0]  gain_d;
  logic [PowerW-1:0] power_max;
  logic [PowerW-1:0] power_min;

  // Loop state
  logic signed [DiffW-1:0] previous_error;
  logic signed [SumW-1:0]  error_integral;

  // Per-item working registers
  logic signed [CountW-1:0] target;
  logic signed [CountW-1:0] measured;
  logic signed [ErrW-1:0]   err;
  logic signed [SumW-1:0]   sum;
  logic signed [DiffW-1:0]  diff;
  logic        [YW-1:0]     ycap;
  logic                     yzero;
  logic                     flag_runaway;

  logic signed [AccW-1:0] acc;
  mac_ctl_t               mac_ctl;

  // Combinational helpers
  logic signed [ErrW-1:0]   err_next;
  logic signed [SumW:0]     sum_wide;
  logic signed [SumW-1:0]   sum_next;
  logic signed [DiffW-1:0]  diff_next;
  logic                     is_runaway;
  logic signed [AccW-1:0]   y;
  logic        [PowerW:0]   power_raw;
  logic        [PowerW-1:0] power_sat;
  logic        [PowerW-1:0] power_hi;
  logic        [PowerW-1:0] power_next;
  logic                     out_free;

  mspid_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  assign sample_ready = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_free     = !result_valid || result_ready;

  // Error, saturating integral and derivative difference
  assign is_runaway = (measured > RunawayLimit) || (measured < -RunawayLimit);
  assign err_next   = ErrW'(target) - ErrW'(measured);
  assign sum_wide   = (SumW + 1)'(error_integral) + (SumW + 1)'(err_next);
  always_comb begin
    case (sum_wide[SumW:SumW-1])
      2'b01:   sum_next = {1'b0, {(SumW - 1){1'b1}}};
      2'b10:   sum_next = {1'b1, {(SumW - 1){1'b0}}};
      default: sum_next = sum_wide[SumW-1:0];
    endcase
  end
  assign diff_next = DiffW'(err) - previous_error;

  // Offset the corrected target before the reciprocal multiply
  assign y = acc + OffsetQ12;

  // Truncate the scaled power, saturate, then apply max and min clamps
  assign power_raw = acc[RecipShift+PowerW:RecipShift];
  always_comb begin
    if (yzero) begin
      power_sat = '0;
    end else if (power_raw[PowerW]) begin
      power_sat = PowerSat;
    end else begin
      power_sat = power_raw[PowerW-1:0];
    end
    power_hi   = (power_sat > power_max) ? power_max : power_sat;
    power_next = (power_hi < power_min) ? power_min : power_hi;
  end

  // Operand selection for the shared multiplier
  always_comb begin
    mac_ctl.op   = MAC_HOLD;
    mac_ctl.opa  = '0;
    mac_ctl.opb  = '0;
    mac_ctl.init = AccW'(target) <<< FracW;
    case (state)
      ST_ERR: begin
        mac_ctl.op = MAC_SET;
      end
      ST_MP: begin
        mac_ctl.op  = MAC_ADD;
        mac_ctl.opa = OpaW'(err);
        mac_ctl.opb = OpbW'(gain_p);
      end
      ST_MI: begin
        mac_ctl.op  = MAC_ADD;
        mac_ctl.opa = OpaW'(sum);
        mac_ctl.opb = OpbW'(gain_i);
      end
      ST_MD: begin
        mac_ctl.op  = MAC_ADD;
        mac_ctl.opa = OpaW'(diff);
        mac_ctl.opb = OpbW'(gain_d);
      end
      ST_MR: begin
        mac_ctl.op  = MAC_MUL;
        mac_ctl.opa = $signed({{(OpaW - YW){1'b0}}, ycap});
        mac_ctl.opb = RecipQ24;
      end
      default: begin
        mac_ctl.op = MAC_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      result_valid   <= 1'b0;
      gain_p         <= GainPReset;
      gain_i         <= GainIReset;
      gain_d         <= GainDReset;
      power_max      <= PowerMaxReset;
      power_min      <= PowerMinReset;
      previous_error <= '0;
      error_integral <= '0;
    end else begin
      // Config writes; unknown indexes drop
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN_P:    gain_p    <= cfg_data;
          REG_GAIN_I:    gain_i    <= cfg_data;
          REG_GAIN_D:    gain_d    <= cfg_data;
          REG_POWER_MAX: power_max <= cfg_data[PowerW-1:0];
          REG_POWER_MIN: power_min <= cfg_data[PowerW-1:0];
          default: ;
        endcase
      end

      // Drop the taken item; in the last step the register reloads itself
      if (result_valid && result_ready && (state != ST_DONE)) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            target   <= target_count;
            measured <= measured_count;
            state    <= ST_ERR;
          end
        end
        ST_ERR: begin
          // Runaway skips the loop and leaves its state alone
          flag_runaway <= is_runaway;
          err          <= err_next;
          sum          <= sum_next;
          state        <= is_runaway ? ST_DONE : ST_MP;
        end
        ST_MP: begin
          diff  <= diff_next;
          state <= ST_MI;
        end
        ST_MI: begin
          state <= ST_MD;
        end
        ST_MD: begin
          previous_error <= DiffW'(err);
          error_integral <= sum;
          state          <= ST_OFS;
        end
        ST_OFS: begin
          yzero <= y[AccW-1] || (y == '0);
          ycap  <= (|y[AccW-2:YW]) ? {YW{1'b1}} : y[YW-1:0];
          state <= ST_MR;
        end
        ST_MR: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Hold here while an earlier result still waits
          if (out_free) begin
            result_valid <= 1'b1;
            motor_power  <= flag_runaway ? RunawayPower : power_next;
            runaway      <= flag_runaway;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
